[sv/mwsm_pkg.sv]
// Shared types and constants for the mecanum wheel speed mixer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mwsm_pkg;

  localparam int NumWheels = 4;

  localparam int SpeedW    = 16;                // command and wheel speed fields
  localparam int LimW      = 15;                // clamp limits, wheel limit
  localparam int RatioW    = 16;                // Q8.8 turn ratios
  localparam int RpmRatioW = 24;                // Q0.24 rpm ratio
  localparam int TurnW     = SpeedW + RatioW + 1; // signed turn term
  localparam int SumW      = TurnW;             // signed Q24.8 wheel sum
  localparam int MagW      = SumW - 1;          // magnitude of a wheel sum
  localparam int WholeW    = MagW + RpmRatioW - 32; // integer rpm part
  localparam int AbsW      = SpeedW;            // |rpm| up to 32768
  localparam int DivW      = AbsW + LimW;       // |rpm| * wheel limit
  localparam int QuoW      = LimW;              // scaled speed never exceeds limit
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 24;

  localparam logic [LimW-1:0]      RstMaxForward = 15'd3300;
  localparam logic [LimW-1:0]      RstMaxSide    = 15'd3300;
  localparam logic [LimW-1:0]      RstMaxTurn    = 15'd300;
  localparam logic [LimW-1:0]      RstMaxWheel   = 15'd8500;
  localparam logic [RatioW-1:0]    RstFrontRatio = 16'd2227;
  localparam logic [RatioW-1:0]    RstBackRatio  = 16'd2227;
  localparam logic [RpmRatioW-1:0] RstRpmRatio   = 24'd110727;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MAX_FORWARD = 3'd0,
    REG_MAX_SIDE    = 3'd1,
    REG_MAX_TURN    = 3'd2,
    REG_MAX_WHEEL   = 3'd3,
    REG_FRONT_RATIO = 3'd4,
    REG_BACK_RATIO  = 3'd5,
    REG_RPM_RATIO   = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [LimW-1:0]      max_forward_speed;
    logic [LimW-1:0]      max_side_speed;
    logic [LimW-1:0]      max_turn_speed;
    logic [LimW-1:0]      max_wheel_speed;
    logic [RatioW-1:0]    front_turn_ratio;
    logic [RatioW-1:0]    back_turn_ratio;
    logic [RpmRatioW-1:0] speed_to_rpm_ratio;
  } cfg_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] forward_speed;
    logic signed [SpeedW-1:0] side_speed;
    logic signed [SpeedW-1:0] turn_speed;
  } cmd_t;

  typedef struct packed {
    logic signed [SpeedW-1:0] wheel_front_right;
    logic signed [SpeedW-1:0] wheel_front_left;
    logic signed [SpeedW-1:0] wheel_back_left;
    logic signed [SpeedW-1:0] wheel_back_right;
    logic                     was_scaled;
  } res_t;

  // Clamped command with the turn terms already multiplied out.
  typedef struct packed {
    logic signed [SpeedW-1:0] vx;
    logic signed [SpeedW-1:0] vy;
    logic signed [TurnW-1:0]  tf;
    logic signed [TurnW-1:0]  tb;
  } mix_t;

  // Requests still in the front stages, for queue credit.
  typedef struct packed {
    logic f0_valid;
    logic f1_valid;
  } front_status_t;

endpackage

`default_nettype wire

[sv/mwsm_front.sv]
// Front end: clamps the chassis request and forms the two turn products.
// Uses mwsm_pkg; feeds mwsm_fifo.
`default_nettype none

module mwsm_front import mwsm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire cmd_t          cmd_i,
  input  wire cfg_t          cfg_i,
  output logic               mix_valid_o,
  output mix_t               mix_o,
  output front_status_t      status_o
);

  function automatic logic signed [SpeedW-1:0] clamp_sym(
    input logic signed [SpeedW-1:0] x,
    input logic [LimW-1:0]          lim
  );
    logic signed [SpeedW:0] xs;
    logic signed [SpeedW:0] ls;
    logic signed [SpeedW:0] r;
    xs = (SpeedW+1)'(x);
    ls = $signed({2'b00, lim});
    if (xs > ls) begin
      r = ls;
    end else if (xs < -ls) begin
      r = -ls;
    end else begin
      r = xs;
    end
    return r[SpeedW-1:0];
  endfunction

  logic                     v0_q, v1_q;
  logic signed [SpeedW-1:0] vx0_q, vy0_q, vw0_q;
  mix_t                     mix_d, mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= accept_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vx0_q <= clamp_sym(cmd_i.forward_speed, cfg_i.max_forward_speed);
    vy0_q <= clamp_sym(cmd_i.side_speed, cfg_i.max_side_speed);
    vw0_q <= clamp_sym(cmd_i.turn_speed, cfg_i.max_turn_speed);
    mix_q <= mix_d;
  end

  always_comb begin
    mix_d.vx = vx0_q;
    mix_d.vy = vy0_q;
    mix_d.tf = vw0_q * $signed({1'b0, cfg_i.front_turn_ratio});
    mix_d.tb = vw0_q * $signed({1'b0, cfg_i.back_turn_ratio});
  end

  assign mix_valid_o       = v1_q;
  assign mix_o             = mix_q;
  assign status_o.f0_valid = v0_q;
  assign status_o.f1_valid = v1_q;

endmodule

`default_nettype wire

[sv/mwsm_fifo.sv]
// Short queue between front and back of the mixer.
// Uses mwsm_pkg for the entry type.
`default_nettype none

module mwsm_fifo import mwsm_pkg::*; #(
  parameter int Depth = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire mix_t                       push_data_i,
  input  wire logic                       pop_i,
  output mix_t                            pop_data_o,
  output logic                            empty_o,
  output logic [$clog2(Depth+1)-1:0]      count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  mix_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];
  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;

endmodule

`default_nettype wire

[sv/mwsm_back.sv]
// Back end: wheel mixing, rpm conversion, peak search and proportional scaling
// through a bit-per-stage restoring divider. Uses mwsm_pkg; fed by mwsm_fifo.
`default_nettype none

module mwsm_back import mwsm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire mix_t  mix_i,
  input  wire cfg_t  cfg_i,
  output logic       out_valid_o,
  output res_t       result_o
);

  // B0: signed wheel sums -> sign and magnitude
  logic                  v0_q;
  logic [NumWheels-1:0]  neg0_q;
  logic [MagW-1:0]       mag0_q [NumWheels];
  logic signed [SumW-1:0] sum_d [NumWheels];
  logic signed [SumW-1:0] nsum_d [NumWheels];
  logic signed [SumW-1:0] vx_e, vy_e;

  always_comb begin
    vx_e = SumW'(mix_i.vx);
    vy_e = SumW'(mix_i.vy);
    sum_d[0] = ((vx_e - vy_e) <<< 8) - mix_i.tf;
    sum_d[1] = ((vx_e + vy_e) <<< 8) - mix_i.tf;
    sum_d[2] = ((vy_e - vx_e) <<< 8) - mix_i.tb;
    sum_d[3] = ((-vx_e - vy_e) <<< 8) - mix_i.tb;
    for (int i = 0; i < NumWheels; i++) begin
      nsum_d[i] = -sum_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumWheels; i++) begin
      neg0_q[i] <= sum_d[i][SumW-1];
      mag0_q[i] <= sum_d[i][SumW-1] ? nsum_d[i][MagW-1:0] : sum_d[i][MagW-1:0];
    end
  end

  // B1: times Q0.24 ratio, keep integer part
  logic                       v1_q;
  logic [NumWheels-1:0]       neg1_q;
  logic [WholeW-1:0]          whole1_q [NumWheels];
  logic [MagW+RpmRatioW-1:0]  prod_d [NumWheels];

  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      prod_d[i] = mag0_q[i] * cfg_i.speed_to_rpm_ratio;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q <= neg0_q;
    for (int i = 0; i < NumWheels; i++) begin
      whole1_q[i] <= prod_d[i][MagW+RpmRatioW-1:32];
    end
  end

  // B2: saturate to int16 range
  logic                 v2_q;
  logic [NumWheels-1:0] neg2_q;
  logic [AbsW-1:0]      abs2_q [NumWheels];

  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    for (int i = 0; i < NumWheels; i++) begin
      if (neg1_q[i]) begin
        abs2_q[i] <= (whole1_q[i] > WholeW'(32768)) ? AbsW'(32768) : whole1_q[i][AbsW-1:0];
      end else begin
        abs2_q[i] <= (whole1_q[i] > WholeW'(32767)) ? AbsW'(32767) : whole1_q[i][AbsW-1:0];
      end
    end
  end

  // B3: largest magnitude
  logic                 v3_q;
  logic [NumWheels-1:0] neg3_q;
  logic [AbsW-1:0]      abs3_q [NumWheels];
  logic [AbsW-1:0]      peak3_q;
  logic [AbsW-1:0]      m01_d, m23_d;

  always_comb begin
    m01_d = (abs2_q[0] > abs2_q[1]) ? abs2_q[0] : abs2_q[1];
    m23_d = (abs2_q[2] > abs2_q[3]) ? abs2_q[2] : abs2_q[3];
  end

  always_ff @(posedge clk_i) begin
    neg3_q  <= neg2_q;
    abs3_q  <= abs2_q;
    peak3_q <= (m01_d > m23_d) ? m01_d : m23_d;
  end

  // Divider pipeline; stage 0 is loaded with |w| * limit and the peak.
  logic [QuoW:0]        dv_q;
  logic [QuoW:0]        scale_q;
  logic [NumWheels-1:0] neg_q  [QuoW+1];
  logic [AbsW-1:0]      abs_q  [QuoW+1][NumWheels];
  logic [AbsW-1:0]      rem_q  [QuoW+1][NumWheels];
  logic [QuoW-1:0]      lq_q   [QuoW+1][NumWheels];
  logic [AbsW-1:0]      div_q  [QuoW+1];
  logic [DivW-1:0]      dvd_d  [NumWheels];
  logic [AbsW:0]        trial  [QuoW][NumWheels];
  logic [AbsW:0]        diff   [QuoW][NumWheels];
  logic [NumWheels-1:0] ge     [QuoW];

  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      dvd_d[i] = DivW'(abs3_q[i]) * DivW'(cfg_i.max_wheel_speed);
    end
  end

  // one compare-subtract per stage and wheel
  always_comb begin
    for (int s = 0; s < QuoW; s++) begin
      for (int i = 0; i < NumWheels; i++) begin
        trial[s][i] = {rem_q[s][i], lq_q[s][i][QuoW-1]};
        diff[s][i]  = trial[s][i] - {1'b0, div_q[s]};
        ge[s][i]    = trial[s][i] >= {1'b0, div_q[s]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q[0] <= peak3_q > AbsW'(cfg_i.max_wheel_speed);
    neg_q[0]   <= neg3_q;
    div_q[0]   <= peak3_q;
    for (int i = 0; i < NumWheels; i++) begin
      abs_q[0][i] <= abs3_q[i];
      rem_q[0][i] <= dvd_d[i][DivW-1:QuoW];
      lq_q[0][i]  <= dvd_d[i][QuoW-1:0];
    end
    for (int s = 1; s <= QuoW; s++) begin
      scale_q[s] <= scale_q[s-1];
      neg_q[s]   <= neg_q[s-1];
      div_q[s]   <= div_q[s-1];
      for (int i = 0; i < NumWheels; i++) begin
        abs_q[s][i] <= abs_q[s-1][i];
        rem_q[s][i] <= ge[s-1][i] ? diff[s-1][i][AbsW-1:0] : trial[s-1][i][AbsW-1:0];
        lq_q[s][i]  <= {lq_q[s-1][i][QuoW-2:0], ge[s-1][i]};
      end
    end
  end

  // Output register
  logic [SpeedW-1:0] mag_d [NumWheels];
  logic [SpeedW-1:0] w_d   [NumWheels];
  res_t              res_q;
  logic              done_q;

  always_comb begin
    for (int i = 0; i < NumWheels; i++) begin
      mag_d[i] = scale_q[QuoW] ? {1'b0, lq_q[QuoW][i]} : abs_q[QuoW][i];
      w_d[i]   = neg_q[QuoW][i] ? -mag_d[i] : mag_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.wheel_front_right <= w_d[0];
    res_q.wheel_front_left  <= w_d[1];
    res_q.wheel_back_left   <= w_d[2];
    res_q.wheel_back_right  <= w_d[3];
    res_q.was_scaled        <= scale_q[QuoW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      dv_q   <= '0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= in_valid_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      dv_q   <= {dv_q[QuoW-1:0], v3_q};
      done_q <= dv_q[QuoW];
    end
  end

  assign out_valid_o = done_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

[sv/mecanum_wheel_speed_mixer.sv]
// Mecanum wheel speed mixer, top level: config registers, front, queue, back.
// One request per cycle while busy is low. An accepted request passes through 2 front
// stages, the queue slot, 4 mix/rpm/peak stages, one scaling stage, a 15-stage restoring
// divider (one quotient bit per stage) and the result register on its way to done_o.
// done_o marks each result for one cycle; the receiver cannot stall, so with QueueDepth >= 4 busy stays low.
// Reset clears all valid flags and loads the config registers with their defaults.
`default_nettype none

module mecanum_wheel_speed_mixer import mwsm_pkg::*; #(
  parameter int QueueDepth = 4   // >= 2; 4 keeps busy low at full rate
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                start,
  output logic                     busy,
  input  wire cmd_t                cmd_i,
  // config write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // result channel
  output logic                     done_o,
  output res_t                     result_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  cfg_t          cfg_q;
  logic          accept;
  logic          mix_valid;
  mix_t          mix_front, mix_back;
  front_status_t front_st;
  logic          q_empty;
  logic [CntW-1:0] q_count;
  logic [CntW:0]   occupancy;

  // Config registers: always ready, unknown indexes dropped, upper bits dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_forward_speed  <= RstMaxForward;
      cfg_q.max_side_speed     <= RstMaxSide;
      cfg_q.max_turn_speed     <= RstMaxTurn;
      cfg_q.max_wheel_speed    <= RstMaxWheel;
      cfg_q.front_turn_ratio   <= RstFrontRatio;
      cfg_q.back_turn_ratio    <= RstBackRatio;
      cfg_q.speed_to_rpm_ratio <= RstRpmRatio;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_MAX_FORWARD: cfg_q.max_forward_speed  <= cfg_wdata_i[LimW-1:0];
        REG_MAX_SIDE:    cfg_q.max_side_speed     <= cfg_wdata_i[LimW-1:0];
        REG_MAX_TURN:    cfg_q.max_turn_speed     <= cfg_wdata_i[LimW-1:0];
        REG_MAX_WHEEL:   cfg_q.max_wheel_speed    <= cfg_wdata_i[LimW-1:0];
        REG_FRONT_RATIO: cfg_q.front_turn_ratio   <= cfg_wdata_i[RatioW-1:0];
        REG_BACK_RATIO:  cfg_q.back_turn_ratio    <= cfg_wdata_i[RatioW-1:0];
        REG_RPM_RATIO:   cfg_q.speed_to_rpm_ratio <= cfg_wdata_i[RpmRatioW-1:0];
        default: ;
      endcase
    end
  end

  // Credit check: queue entries plus requests still in the two front stages
  // must leave room for one more, since the front cannot stall.
  assign occupancy = (CntW+1)'(q_count) + (CntW+1)'(front_st.f0_valid)
                   + (CntW+1)'(front_st.f1_valid);
  assign busy      = occupancy >= (CntW+1)'(QueueDepth);
  assign accept    = start && !busy;

  // Front: clamp and turn products, two stages.
  mwsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .cfg_i       (cfg_q),
    .mix_valid_o (mix_valid),
    .mix_o       (mix_front),
    .status_o    (front_st)
  );

  // Queue: back drains one entry every cycle it holds any.
  mwsm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (mix_valid),
    .push_data_i (mix_front),
    .pop_i       (!q_empty),
    .pop_data_o  (mix_back),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  // Back: wheel sums, rpm, saturation, peak, proportional scaling.
  mwsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .mix_i       (mix_back),
    .cfg_i       (cfg_q),
    .out_valid_o (done_o),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
